/* hdl/source_text_tokenizer_defines.svh */
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define STT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence in the cycle after the condition.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/stt_pkg.sv */
// Types, constants, keyword table and helpers of the source text tokenizer.
`timescale 1ns / 1ps
package stt_pkg;

	localparam int KEYWORD_CHARS  = 8;
	localparam int COUNT_BITS     = 16;
	localparam int KW_IDX_BITS    = $clog2(KEYWORD_CHARS);
	localparam int KW_COUNT       = 21;
	localparam int KW_MAX_LEN     = 8;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_AMP    = 8'h26;

	typedef enum logic [3:0] {
		M_START, M_ID, M_INT, M_FLOAT, M_STRING, M_LOGIC, M_ARITH, M_REL, M_COMMENT
	} mode_t;

	typedef enum logic [4:0] {
		K_KEYWORD     = 5'd0,
		K_IDENT       = 5'd1,
		K_INT         = 5'd2,
		K_FLOAT       = 5'd3,
		K_STRING      = 5'd4,
		K_LOGIC       = 5'd5,
		K_NOT         = 5'd6,
		K_ARITH       = 5'd7,
		K_REL         = 5'd8,
		K_ASSIGN      = 5'd9,
		K_GROUP       = 5'd10,
		K_BRACKET     = 5'd11,
		K_DELIM       = 5'd12,
		K_ERR_CHAR    = 5'd13,
		K_ERR_FLOAT   = 5'd14,
		K_ERR_STRING  = 5'd15,
		K_ERR_AND     = 5'd16,
		K_ERR_OR      = 5'd17,
		K_ERR_COMMENT = 5'd18
	} kind_t;

	typedef enum logic [3:0] {
		CC_IDSTART, CC_DIGIT, CC_QUOTE, CC_LOGIC, CC_ARITH, CC_REL, CC_DELIM,
		CC_GROUP, CC_BRACKET, CC_SPACE, CC_NUL, CC_NEWLINE, CC_INVALID
	} char_class_t;

	typedef struct packed {
		logic [7:0]  ch;
		char_class_t cls;
	} char_item_t;

	typedef struct packed {
		logic       push;
		char_item_t item;
	} q_write_t;

	typedef struct packed {
		logic       valid;
		char_item_t item;
	} q_head_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  kw;
		logic [15:0] line;
		logic [15:0] len;
		logic [7:0]  c1;
		logic [7:0]  c2;
		logic        last;
	} token_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] idx;
	} kw_hit_t;

	typedef logic [KEYWORD_CHARS-1:0][7:0] prefix_t;

	// Words are right-justified: the first character is the highest byte that the word uses.
	localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
		"var", "int", "float", "string", "bool", "void", "function", "if", "else",
		"while", "for", "inc", "dec", "switch", "case", "default", "print", "read",
		"return", "true", "false"
	};

	localparam int KW_LEN [KW_COUNT] = '{
		3, 3, 5, 6, 4, 4, 8, 2, 4, 5, 3, 3, 3, 6, 4, 7, 5, 4, 6, 4, 5
	};

	// Each table word is compared independently; the lowest index wins.
	function automatic kw_hit_t keyword_match(prefix_t p, logic [COUNT_BITS-1:0] len);
		kw_hit_t r;
		logic    same;
		r = '0;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			same = (len == COUNT_BITS'(KW_LEN[i]));
			for (int j = 0; j < KW_MAX_LEN; j++) begin
				if (j < KW_LEN[i]) begin
					if (KW_TEXT[i][(KW_LEN[i] - 1 - j) * 8 +: 8] != p[j]) begin
						same = 1'b0;
					end
				end
			end
			if (same) begin
				r.hit = 1'b1;
				r.idx = 5'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] cap16(logic [COUNT_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

endpackage

/* hdl/stt_ifs.sv */
// Handshake interfaces for the character input and token output channels.
`timescale 1ns / 1ps
interface stt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	modport source(output valid, output char_code, input ready);
	modport sink(input valid, input char_code, output ready);
endinterface

interface stt_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  kind;
	logic [4:0]  keyword_index;
	logic [15:0] line_number;
	logic [15:0] token_length;
	logic [7:0]  first_char;
	logic [7:0]  second_char;
	logic        last_of_run;
	modport source(output valid, output kind, output keyword_index, output line_number,
		output token_length, output first_char, output second_char, output last_of_run,
		input ready);
	modport sink(input valid, input kind, input keyword_index, input line_number,
		input token_length, input first_char, input second_char, input last_of_run,
		output ready);
endinterface

/* hdl/stt_front.sv */
// Front end: accepts characters and tags each with its character class.
`timescale 1ns / 1ps
module stt_front import stt_pkg::*; (
	stt_char_if.sink chars,
	input  logic     full,
	output q_write_t wr
);

	function automatic char_class_t classify(logic [7:0] c);
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
			return CC_IDSTART;
		end else if (c >= "0" && c <= "9") begin
			return CC_DIGIT;
		end else if (c == CH_DQUOTE) begin
			return CC_QUOTE;
		end else if (c == "&" || c == "|") begin
			return CC_LOGIC;
		end else if (c == "+" || c == "-" || c == "/" || c == "*" || c == "%" || c == "^") begin
			return CC_ARITH;
		end else if (c == "<" || c == ">" || c == "!" || c == "=") begin
			return CC_REL;
		end else if (c == "." || c == "," || c == ";" || c == ":") begin
			return CC_DELIM;
		end else if (c == "(" || c == ")" || c == "{" || c == "}") begin
			return CC_GROUP;
		end else if (c == "[" || c == "]") begin
			return CC_BRACKET;
		end else if (c == " " || c == 8'h09 || c == CH_CR) begin
			return CC_SPACE;
		end else if (c == CH_NUL) begin
			return CC_NUL;
		end else if (c == CH_NL) begin
			return CC_NEWLINE;
		end
		return CC_INVALID;
	endfunction

	assign chars.ready  = !full;
	assign wr.push      = chars.valid && !full;
	assign wr.item.ch   = chars.char_code;
	assign wr.item.cls  = classify(chars.char_code);

endmodule

/* hdl/stt_queue.sv */
// Short queue of classified characters between the front and back ends.
`timescale 1ns / 1ps
module stt_queue import stt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_write_t wr,
	output logic     full,
	output q_head_t  head,
	input  logic     pop
);

	char_item_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;

	assign full       = (count_q == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hdl/stt_back.sv */
// Back end: runs the lexer automaton, one pass a cycle unless stalled, into the token output register.
`timescale 1ns / 1ps
module stt_back import stt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_head_t    head,
	output logic       pop,
	stt_token_if.source tokens
);

	mode_t                 mode_q, mode_d;
	logic [COUNT_BITS-1:0] line_q, line_d;
	logic [COUNT_BITS-1:0] len_q, len_d;
	prefix_t               prefix_q, prefix_d;
	logic [7:0]            lead_q, lead_d;
	logic                  dot_q, dot_d;
	logic                  star_q, star_d;
	logic                  ov_q;
	token_t                ev_q;

	logic                  go;
	logic                  consume;
	logic                  emit;
	logic                  do_begin;
	logic                  do_grow;
	logic                  start_emits;
	kind_t                 ev_kind;
	logic [4:0]            ev_kw;
	logic [COUNT_BITS-1:0] ev_len;
	logic [7:0]            ev_c1;
	logic [7:0]            ev_c2;
	logic [COUNT_BITS-1:0] len_inc;
	logic [COUNT_BITS-1:0] len_base;
	logic [7:0]            c;
	char_class_t           cls;
	kw_hit_t               kw;

	assign c   = head.item.ch;
	assign cls = head.item.cls;
	assign go  = head.valid && (!ov_q || tokens.ready);
	assign pop = go && consume;

	assign len_inc = (len_q != COUNT_MAX) ? len_q + 1'b1 : len_q;
	assign kw      = keyword_match(prefix_q, len_q);

	// In start mode these classes give an event of their own, so a token closed
	// by such a character is not the last event of the run.
	assign start_emits = (cls == CC_DELIM) || (cls == CC_GROUP) ||
		(cls == CC_BRACKET) || (cls == CC_INVALID);

	always_comb begin
		mode_d   = mode_q;
		line_d   = line_q;
		len_d    = len_q;
		prefix_d = prefix_q;
		lead_d   = lead_q;
		dot_d    = dot_q;
		star_d   = star_q;
		consume  = 1'b1;
		emit     = 1'b0;
		do_begin = 1'b0;
		do_grow  = 1'b0;
		ev_kind  = K_IDENT;
		ev_kw    = '0;
		ev_len   = COUNT_BITS'(1);
		ev_c1    = lead_q;
		ev_c2    = '0;
		case (mode_q)
			M_START: begin
				ev_c1 = c;
				case (cls)
					CC_IDSTART: begin do_begin = 1'b1; mode_d = M_ID;     end
					CC_DIGIT:   begin do_begin = 1'b1; mode_d = M_INT;    end
					CC_QUOTE:   begin do_begin = 1'b1; mode_d = M_STRING; end
					CC_LOGIC:   begin do_begin = 1'b1; mode_d = M_LOGIC;  end
					CC_ARITH:   begin do_begin = 1'b1; mode_d = M_ARITH;  end
					CC_REL:     begin do_begin = 1'b1; mode_d = M_REL;    end
					CC_DELIM:   begin emit = 1'b1; ev_kind = K_DELIM;    end
					CC_GROUP:   begin emit = 1'b1; ev_kind = K_GROUP;    end
					CC_BRACKET: begin emit = 1'b1; ev_kind = K_BRACKET;  end
					CC_SPACE:   begin end
					CC_NUL:     line_d = COUNT_BITS'(1);
					CC_NEWLINE: begin
						if (line_q != COUNT_MAX) begin
							line_d = line_q + 1'b1;
						end
					end
					default:    begin emit = 1'b1; ev_kind = K_ERR_CHAR; end
				endcase
				if (do_begin) begin
					do_grow = 1'b1;
					lead_d  = c;
					dot_d   = 1'b0;
					star_d  = 1'b0;
				end
			end
			M_ID: begin
				if (cls == CC_IDSTART || cls == CC_DIGIT) begin
					do_grow = 1'b1;
				end else begin
					emit    = 1'b1;
					ev_kind = kw.hit ? K_KEYWORD : K_IDENT;
					ev_kw   = kw.hit ? kw.idx : 5'd0;
					ev_len  = len_q;
					consume = 1'b0;
					mode_d  = M_START;
				end
			end
			M_INT: begin
				if (c == CH_DOT) begin
					do_grow = 1'b1;
					dot_d   = 1'b1;
					mode_d  = M_FLOAT;
				end else if (cls == CC_DIGIT) begin
					do_grow = 1'b1;
				end else begin
					emit    = 1'b1;
					ev_kind = K_INT;
					ev_len  = len_q;
					consume = 1'b0;
					mode_d  = M_START;
				end
			end
			M_FLOAT: begin
				if (cls == CC_DIGIT) begin
					do_grow = 1'b1;
					dot_d   = 1'b0;
				end else begin
					emit    = 1'b1;
					ev_kind = dot_q ? K_ERR_FLOAT : K_FLOAT;
					ev_len  = len_q;
					consume = 1'b0;
					mode_d  = M_START;
				end
			end
			M_STRING: begin
				if (c == CH_DQUOTE) begin
					do_grow = 1'b1;
					emit    = 1'b1;
					ev_kind = K_STRING;
					ev_len  = len_inc;
					mode_d  = M_START;
				end else if (c == CH_NUL || c == CH_NL || c == CH_CR) begin
					emit    = 1'b1;
					ev_kind = K_ERR_STRING;
					ev_len  = len_q;
					consume = 1'b0;
					mode_d  = M_START;
				end else begin
					do_grow = 1'b1;
				end
			end
			M_LOGIC: begin
				emit   = 1'b1;
				mode_d = M_START;
				if (c == lead_q) begin
					ev_kind = K_LOGIC;
					ev_len  = COUNT_BITS'(2);
					ev_c2   = c;
				end else begin
					ev_kind = (lead_q == CH_AMP) ? K_ERR_AND : K_ERR_OR;
					consume = 1'b0;
				end
			end
			M_ARITH: begin
				if (lead_q == CH_SLASH && c == CH_STAR) begin
					len_d  = '0;
					lead_d = '0;
					star_d = 1'b0;
					mode_d = M_COMMENT;
				end else begin
					emit    = 1'b1;
					ev_kind = K_ARITH;
					consume = 1'b0;
					mode_d  = M_START;
				end
			end
			M_REL: begin
				emit   = 1'b1;
				mode_d = M_START;
				if (c == CH_EQ) begin
					ev_kind = K_REL;
					ev_len  = COUNT_BITS'(2);
					ev_c2   = c;
				end else begin
					consume = 1'b0;
					if (lead_q == CH_BANG) begin
						ev_kind = K_NOT;
					end else if (lead_q == CH_EQ) begin
						ev_kind = K_ASSIGN;
					end else begin
						ev_kind = K_REL;
					end
				end
			end
			M_COMMENT: begin
				if (c == CH_NUL) begin
					emit    = 1'b1;
					ev_kind = K_ERR_COMMENT;
					ev_len  = len_q;
					consume = 1'b0;
					mode_d  = M_START;
				end else if (c == CH_SLASH && star_q) begin
					star_d = 1'b0;
					mode_d = M_START;
				end else begin
					if (len_q == '0) begin
						lead_d = c;
					end
					len_d  = len_inc;
					star_d = (c == CH_STAR);
				end
			end
			default: begin
				consume = 1'b0;
				mode_d  = M_START;
			end
		endcase

		// A new token restarts its length before the first character is added.
		len_base = do_begin ? '0 : len_q;
		if (do_grow) begin
			if (len_base < COUNT_BITS'(KEYWORD_CHARS)) begin
				prefix_d[len_base[KW_IDX_BITS-1:0]] = c;
			end
			len_d = (len_base != COUNT_MAX) ? len_base + 1'b1 : len_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_START;
			line_q   <= COUNT_BITS'(1);
			len_q    <= '0;
			prefix_q <= '0;
			lead_q   <= '0;
			dot_q    <= 1'b0;
			star_q   <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (go) begin
				mode_q   <= mode_d;
				line_q   <= line_d;
				len_q    <= len_d;
				prefix_q <= prefix_d;
				lead_q   <= lead_d;
				dot_q    <= dot_d;
				star_q   <= star_d;
			end
			if (go && emit) begin
				ov_q <= 1'b1;
			end else if (tokens.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			ev_q.kind <= ev_kind;
			ev_q.kw   <= ev_kw;
			ev_q.line <= cap16(line_q);
			ev_q.len  <= cap16(ev_len);
			ev_q.c1   <= ev_c1;
			ev_q.c2   <= ev_c2;
			ev_q.last <= consume || !start_emits;
		end
	end

	assign tokens.valid         = ov_q;
	assign tokens.kind          = ev_q.kind;
	assign tokens.keyword_index = ev_q.kw;
	assign tokens.line_number   = ev_q.line;
	assign tokens.token_length  = ev_q.len;
	assign tokens.first_char    = ev_q.c1;
	assign tokens.second_char   = ev_q.c2;
	assign tokens.last_of_run   = ev_q.last;

endmodule

/* hdl/source_text_tokenizer.sv */
// Top level of the source text tokenizer: front end, character queue and lexer back end.
//
// Channel   Role    Payload
// chars     sink    char_code (one source byte per item, 0 ends the text)
// tokens    source  kind, keyword_index, line_number, token_length,
//                   first_char, second_char, last_of_run
//
// A character is taken in any cycle in which the queue has room. The back end makes one
// pass of the automaton a cycle while a character waits and the output is free; a
// character that closes a token without belonging to it gives two items when its second
// pass meets a delimiter, bracket, grouping symbol or invalid byte. Reset puts the lexer
// in its start mode with the line count at one and empties the four-entry queue. The
// queue lets input continue for up to four characters while the token channel stalls.
`timescale 1ns / 1ps
`include "source_text_tokenizer_defines.svh"
module source_text_tokenizer import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	stt_char_if.sink    chars,
	stt_token_if.source tokens
);

	q_write_t wr;
	q_head_t  head;
	logic     full;
	logic     pop;

	stt_front u_front (
		.chars (chars),
		.full  (full),
		.wr    (wr)
	);

	stt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.full   (full),
		.head   (head),
		.pop    (pop)
	);

	stt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.tokens (tokens)
	);

	`STT_ASSERT_NOW(a_no_push_when_full, wr.push, !full, "character pushed into a full queue")
	`STT_ASSERT_NOW(a_pop_needs_item, pop, head.valid, "queue popped while empty")
	`STT_ASSERT_NEXT(a_second_event_follows,
		tokens.valid && tokens.ready && !tokens.last_of_run,
		tokens.valid && (tokens.kind == K_DELIM || tokens.kind == K_GROUP ||
		tokens.kind == K_BRACKET || tokens.kind == K_ERR_CHAR),
		"item not marked last was not followed by its start-mode item")

endmodule
